>>> rtl/hex_text_record_parser_defines.svh
// Assertion macros for the hex text record parser.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef HEX_TEXT_RECORD_PARSER_DEFINES_SVH
`define HEX_TEXT_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define HEXP_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define HEXP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/hexp_pkg.sv
// Shared types and constants for the hex text record parser.
// No dependencies; used by every module of the block.
package hexp_pkg;

    // Record length and queue depth defaults, width of the index field
    localparam int RECORD_BYTES_DEF = 20;
    localparam int ADDR_W           = 5;
    localparam int FIFO_DEPTH_DEF   = 4;

    // Characters with special meaning
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_NUL  = 8'h00;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;

    // Parser modes
    typedef enum logic [2:0] {
        PM_FIRST,
        PM_SECOND,
        PM_COMMENT,
        PM_AFTERCR,
        PM_DONE
    } t_parse_mode;

    // Back end states
    typedef enum logic [0:0] {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // Commands from front to back
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_EMIT,
        CMD_ERR,
        CMD_EOF
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op           op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_cmd;

    // Push side of the command queue
    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_cmd_push;

endpackage

>>> rtl/hex_text_record_parser.sv
// Hex text record parser: one text byte per input item, records out.
// Stream in on s_axis (tdata = character), results out on m_axis:
//   tdata[7:0] record byte, tdata[12:8] its index, tuser kind
//   (record byte, format error, end of file), tlast on the final result.
// The front parser takes one character per cycle while the command queue has
// room; each decoded pair becomes one write command to the back end, and a
// record is sent from the line store as RECORD_BYTES items, one per cycle
// while m_axis_tready is high. The byte taken after the CR starts a record,
// which passes the queue, the back end's EMIT state, the read stage and the
// output register; an error or end-of-file result passes the queue, the read
// stage and the output register. The back end takes no command while a record
// goes out, so input stalls when the queue of FIFO_DEPTH fills.
// After an error or end of file the input is still taken but ignored until
// reset. Reset (synchronous, i_rst_n low) empties the queue and returns the
// parser to the start of a line; the line store needs no clearing.
// When the receiver stalls, the output register and a read stage hold their
// items, then the queue fills and s_axis_tready drops.
// Depends on hexp_pkg, hexp_front, hexp_fifo, hexp_back and the defines header.
`include "hex_text_record_parser_defines.svh"

module hex_text_record_parser #(
    parameter int RECORD_BYTES = hexp_pkg::RECORD_BYTES_DEF,
    parameter int FIFO_DEPTH   = hexp_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [12:8] byte_index, [15:13] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);
    hexp_pkg::t_cmd_push q_wr;
    hexp_pkg::t_cmd      q_cmd;
    logic                q_full, q_empty, q_pop;

    hexp_front #(.RECORD_BYTES(RECORD_BYTES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_full        (q_full),
        .o_wr          (q_wr)
    );

    hexp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    hexp_back #(.RECORD_BYTES(RECORD_BYTES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_cmd),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Front never pushes into a full queue
    `HEXP_ASSERT_IMPL(a_no_push_full, q_wr.push, !q_full, "push into full command queue")

    // Error and end-of-file results are always the final result
    `HEXP_ASSERT_IMPL(a_status_last, m_axis_tvalid && m_axis_tuser != hexp_pkg::KIND_DATA,
        m_axis_tlast, "status result without tlast")

    // Nothing follows a delivered error or end of file
    `HEXP_ASSERT_NEXT(a_quiet_after_status,
        m_axis_tvalid && m_axis_tready && m_axis_tuser != hexp_pkg::KIND_DATA,
        !m_axis_tvalid, "result after error or end of file")

    // Final record byte carries the last index
    `HEXP_ASSERT_IMPL(a_last_index,
        m_axis_tvalid && m_axis_tlast && m_axis_tuser == hexp_pkg::KIND_DATA,
        m_axis_tdata[12:8] == 5'(RECORD_BYTES - 1), "record ends at wrong index")
endmodule

>>> rtl/hexp_fifo.sv
// Short command queue between the parser front and the record back end.
// Depends on hexp_pkg for the command type.
module hexp_fifo #(
    parameter int DEPTH = hexp_pkg::FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hexp_pkg::t_cmd_push i_wr,
    output logic              o_full,
    input  logic              i_pop,
    output hexp_pkg::t_cmd    o_cmd,
    output logic              o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hexp_pkg::t_cmd   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_wr.cmd;
        end
    end
endmodule

>>> rtl/hexp_front.sv
// Parser front: accepts text bytes, decodes hex pairs and classifies lines.
// Depends on hexp_pkg; pushes one command per item at most into the queue.
module hexp_front #(
    parameter int RECORD_BYTES = hexp_pkg::RECORD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] char_in
    input  logic                i_full,
    output hexp_pkg::t_cmd_push o_wr
);
    localparam int CNT_W = $clog2(RECORD_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_REC = CNT_W'(RECORD_BYTES);

    hexp_pkg::t_parse_mode r_mode, n_mode;
    logic [3:0]            r_held, n_held;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  accept;
    logic [7:0]            ch;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'd87;
        end
        return d[3:0];
    endfunction

    assign s_axis_tready = !i_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ch            = fold_case(s_axis_tdata);

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (accept) begin
            case (r_mode)
                hexp_pkg::PM_FIRST: begin
                    if (ch == hexp_pkg::CHAR_HASH) begin
                        n_mode = hexp_pkg::PM_COMMENT;
                    end else if (ch == hexp_pkg::CHAR_CR) begin
                        n_mode = hexp_pkg::PM_AFTERCR;
                    end else if (ch == hexp_pkg::CHAR_NUL) begin
                        n_mode = hexp_pkg::PM_DONE;
                    end else begin
                        n_mode = hexp_pkg::PM_SECOND;
                    end
                end
                hexp_pkg::PM_SECOND: begin
                    n_mode = (r_count == CNT_REC) ? hexp_pkg::PM_DONE : hexp_pkg::PM_FIRST;
                end
                hexp_pkg::PM_COMMENT: begin
                    if (s_axis_tdata == hexp_pkg::CHAR_NUL) begin
                        n_mode = hexp_pkg::PM_DONE;
                    end else if (s_axis_tdata == hexp_pkg::CHAR_CR) begin
                        n_mode = hexp_pkg::PM_AFTERCR;
                    end
                end
                hexp_pkg::PM_AFTERCR: begin
                    if (r_count == '0 || r_count == CNT_REC) begin
                        n_mode = hexp_pkg::PM_FIRST;
                    end else begin
                        n_mode = hexp_pkg::PM_DONE;
                    end
                end
                default: n_mode = hexp_pkg::PM_DONE;
            endcase
        end
    end

    // Commands, line count and held nibble
    always_comb begin
        o_wr.push     = 1'b0;
        o_wr.cmd.op   = hexp_pkg::CMD_WRITE;
        o_wr.cmd.addr = hexp_pkg::ADDR_W'(r_count);
        o_wr.cmd.data = {r_held, nibble_of(ch)};
        n_count       = r_count;
        n_held        = r_held;
        if (accept) begin
            case (r_mode)
                hexp_pkg::PM_FIRST: begin
                    if (ch == hexp_pkg::CHAR_NUL) begin
                        o_wr.push   = 1'b1;
                        o_wr.cmd.op = hexp_pkg::CMD_EOF;
                    end else if (ch != hexp_pkg::CHAR_HASH && ch != hexp_pkg::CHAR_CR) begin
                        n_held = nibble_of(ch);
                    end
                end
                hexp_pkg::PM_SECOND: begin
                    o_wr.push = 1'b1;
                    if (r_count == CNT_REC) begin
                        o_wr.cmd.op = hexp_pkg::CMD_ERR;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_held  = 4'd0;
                    end
                end
                hexp_pkg::PM_COMMENT: begin
                    if (s_axis_tdata == hexp_pkg::CHAR_NUL) begin
                        o_wr.push   = 1'b1;
                        o_wr.cmd.op = hexp_pkg::CMD_EOF;
                    end
                end
                hexp_pkg::PM_AFTERCR: begin
                    if (r_count == CNT_REC) begin
                        o_wr.push   = 1'b1;
                        o_wr.cmd.op = hexp_pkg::CMD_EMIT;
                        n_count     = '0;
                    end else if (r_count != '0) begin
                        o_wr.push   = 1'b1;
                        o_wr.cmd.op = hexp_pkg::CMD_ERR;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= hexp_pkg::PM_FIRST;
            r_held  <= 4'd0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end
endmodule

>>> rtl/hexp_back.sv
// Record back end: owns the line store, writes bytes, emits records and status results.
// Depends on hexp_pkg; reads commands from the queue, drives the result stream.
module hexp_back #(
    parameter int RECORD_BYTES = hexp_pkg::RECORD_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hexp_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [15:0]    m_axis_tdata,   // [7:0] data_byte, [12:8] byte_index, [15:13] zero
    output logic [1:0]     m_axis_tuser,   // [1:0] kind
    output logic           m_axis_tlast    // last
);
    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RECORD_BYTES - 1);

    hexp_pkg::t_back_state r_state, n_state;
    logic [7:0]       r_mem [RECORD_BYTES];
    logic [IDX_W-1:0] r_idx;

    // Read stage
    logic             r_rd_valid;
    logic [7:0]       r_rd_data;
    logic [1:0]       r_rd_kind;
    logic [IDX_W-1:0] r_rd_index;
    logic             r_rd_last;

    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic [1:0]       r_out_kind;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_last;

    logic       out_free, adv1;
    logic       mem_we, rd_issue, ld1, ld1_last;
    logic [1:0] ld1_kind;

    assign out_free = !r_out_valid || m_axis_tready;
    assign adv1     = !r_rd_valid || out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hexp_pkg::BK_IDLE: begin
                if (!i_empty && i_cmd.op == hexp_pkg::CMD_EMIT) begin
                    n_state = hexp_pkg::BK_EMIT;
                end
            end
            hexp_pkg::BK_EMIT: begin
                if (adv1 && r_idx == IDX_LAST) begin
                    n_state = hexp_pkg::BK_IDLE;
                end
            end
            default: n_state = hexp_pkg::BK_IDLE;
        endcase
    end

    // Pop, store writes and read-stage loads
    always_comb begin
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        rd_issue = 1'b0;
        ld1      = 1'b0;
        ld1_kind = hexp_pkg::KIND_DATA;
        ld1_last = 1'b1;
        case (r_state)
            hexp_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.op)
                        hexp_pkg::CMD_WRITE: begin
                            o_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        hexp_pkg::CMD_EMIT: o_pop = 1'b1;
                        hexp_pkg::CMD_ERR: begin
                            o_pop    = adv1;
                            ld1      = adv1;
                            ld1_kind = hexp_pkg::KIND_ERR;
                        end
                        hexp_pkg::CMD_EOF: begin
                            o_pop    = adv1;
                            ld1      = adv1;
                            ld1_kind = hexp_pkg::KIND_EOF;
                        end
                        default: ;
                    endcase
                end
            end
            hexp_pkg::BK_EMIT: begin
                rd_issue = adv1;
                ld1      = adv1;
                ld1_last = (r_idx == IDX_LAST);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hexp_pkg::BK_IDLE;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hexp_pkg::BK_IDLE) begin
                r_idx <= '0;
            end else if (adv1) begin
                r_idx <= r_idx + 1'b1;
            end
            if (adv1) begin
                r_rd_valid <= ld1;
            end
            if (out_free) begin
                r_out_valid <= r_rd_valid;
            end
        end
    end

    // Line store write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.addr[IDX_W-1:0]] <= i_cmd.data;
        end
    end

    // Read stage and output payload
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_rd_data  <= rd_issue ? r_mem[r_idx] : 8'd0;
            r_rd_kind  <= ld1_kind;
            r_rd_index <= rd_issue ? r_idx : '0;
            r_rd_last  <= ld1_last;
        end
        if (out_free && r_rd_valid) begin
            r_out_data  <= r_rd_data;
            r_out_kind  <= r_rd_kind;
            r_out_index <= r_rd_index;
            r_out_last  <= r_rd_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, hexp_pkg::ADDR_W'(r_out_index), r_out_data};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
endmodule
